// File: rtl/dcvf_pkg.sv
// shared types, constants and helpers for the dual comb voicing filter
package dcvf_pkg;

	localparam int CHANNELS    = 16;
	localparam int RING_DEPTH  = 2048;
	localparam int SAMPLE_BITS = 24;

	localparam int CH_BITS   = 4;
	localparam int CHI_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int POS_BITS  = $clog2(RING_DEPTH);
	localparam int MEM_DEPTH = CHANNELS * RING_DEPTH;
	localparam int ADDR_BITS = $clog2(MEM_DEPTH);
	localparam int ACC_BITS  = SAMPLE_BITS + 20;
	localparam int MIX_BITS  = ACC_BITS + 18;

	localparam logic [15:0] LEVEL_LOW  = 16'd655;
	localparam logic [15:0] LEVEL_HIGH = 16'd64880;
	localparam logic [12:0] SLIDE_GAIN = 13'd5033;
	localparam logic [6:0]  SQ_GAIN    = 7'd77;
	localparam logic [17:0] OFFA_BASE  = 18'd209715;
	localparam logic [17:0] OFFB_GAIN  = 18'd252314;
	localparam logic [22:0] OFFB_BASE  = 23'd2686976;
	localparam logic [15:0] GAIN_A_MID = 16'd17957;
	localparam logic [15:0] GAIN_A_OUT = 16'd7021;
	localparam logic [15:0] GAIN_B_MID = 16'd41222;
	localparam logic [15:0] GAIN_B_OUT = 16'd37842;

	// register indexes
	localparam logic [1:0] REG_RATE   = 2'd0;
	localparam logic [1:0] REG_NARROW = 2'd1;
	localparam logic [1:0] REG_WIDE   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SLIDE, ST_OFFA, ST_OFFB, ST_TAPS, ST_READ, ST_DRAIN, ST_MIX, ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       slide;
		logic       offa;
		logic       offb;
		logic       taps;
		logic       rd;
		logic [2:0] tap_idx;
		logic       acc_en;
		logic [2:0] acc_idx;
		logic       mix;
		logic       out_load;
	} dp_cmd_t;

	function automatic logic [15:0] clamp_level(input logic [15:0] v);
		if (v < LEVEL_LOW) return LEVEL_LOW;
		if (v > LEVEL_HIGH) return LEVEL_HIGH;
		return v;
	endfunction

endpackage

// File: rtl/dcvf_if.sv
// valid/ready channel interfaces for requests and results
interface dcvf_in_if;
	import dcvf_pkg::*;
	logic                          valid;
	logic                          ready;
	logic [CH_BITS-1:0]            channel;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic [15:0]                   voicing;
	logic [15:0]                   intensity;
	modport source (output valid, channel, sample_in, voicing, intensity, input ready);
	modport sink (input valid, channel, sample_in, voicing, intensity, output ready);
endinterface

interface dcvf_out_if;
	import dcvf_pkg::*;
	logic                          valid;
	logic                          ready;
	logic [CH_BITS-1:0]            channel_out;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	modport source (output valid, channel_out, sample_out, input ready);
	modport sink (input valid, channel_out, sample_out, output ready);
endinterface

// File: rtl/dual_comb_voicing_filter_core.sv
// top level of the dual comb voicing filter
// Usage:
// Requests arrive on in_ch (channel, sample_in, voicing, intensity) and
// results leave on out_ch (channel_out, sample_out), both valid/ready.
// A request is taken when valid and ready are both high; the block works on
// one request at a time. A request passes the slide, offset, tap, read,
// drain, mix and output states, and a new request is taken the cycle after
// the result is loaded; the pace is set by the six serial reads of the
// single read port of the delay ring plus the offset multiply chain.
// The result waits in an output register; while the receiver stalls, the
// block finishes the next request up to the output and then holds.
// Configuration: cfg_we with cfg_index 0 rate_scale, 1 narrow_spacing,
// 2 wide_spacing, taken at any edge, meant to be written while idle.
// After reset the delay ring is cleared one entry a cycle, all 32768 entries,
// during which no request is accepted.
module dual_comb_voicing_filter_core
	import dcvf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	dcvf_in_if.sink     in_ch,
	dcvf_out_if.source  out_ch
);
	dp_cmd_t cmd;
	logic    clr_busy;

	dcvf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.clr_busy(clr_busy), .cmd(cmd)
	);

	dcvf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.channel(in_ch.channel), .sample_in(in_ch.sample_in),
		.voicing(in_ch.voicing), .intensity(in_ch.intensity),
		.clr_busy(clr_busy),
		.channel_out(out_ch.channel_out), .sample_out(out_ch.sample_out)
	);
endmodule

// File: rtl/dcvf_ram.sv
// generic single-port-write, one-read ram with registered read data
module dcvf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/dcvf_ctrl.sv
// controller state machine sequencing one request through the datapath
module dcvf_ctrl
	import dcvf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  logic    clr_busy,
	output dp_cmd_t cmd
);
	state_t     state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	logic       ovalid_q;

	// next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE:  if (in_valid && !clr_busy) state_d = ST_SLIDE;
			ST_SLIDE: state_d = ST_OFFA;
			ST_OFFA:  state_d = ST_OFFB;
			ST_OFFB:  state_d = ST_TAPS;
			ST_TAPS:  begin state_d = ST_READ; cnt_d = 3'd0; end
			ST_READ:  begin
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'd5) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_MIX;
			ST_MIX:   state_d = ST_OUT;
			ST_OUT:   if (!ovalid_q || out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE:  begin
				in_ready = !clr_busy;
				cmd.load = in_valid && in_ready;
			end
			ST_SLIDE: cmd.slide = 1'b1;
			ST_OFFA:  cmd.offa = 1'b1;
			ST_OFFB:  cmd.offb = 1'b1;
			ST_TAPS:  cmd.taps = 1'b1;
			ST_READ:  begin
				cmd.rd      = 1'b1;
				cmd.tap_idx = cnt_q;
				cmd.acc_en  = cnt_q != 3'd0;
				cmd.acc_idx = cnt_q - 3'd1;
			end
			ST_DRAIN: begin cmd.acc_en = 1'b1; cmd.acc_idx = 3'd5; end
			ST_MIX:   cmd.mix = 1'b1;
			ST_OUT:   cmd.out_load = !ovalid_q || out_ready;
			default:  cmd = '0;
		endcase
	end

	assign out_valid = ovalid_q;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_SLIDE)
		else $error("request did not start");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready)
		else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
endmodule

// File: rtl/dcvf_datapath.sv
// datapath: voicing smoothing, tap offsets, ring access, accumulate and mix
module dcvf_datapath
	import dcvf_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_cmd_t                       cmd,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [14:0]                   cfg_data,
	input  logic [CH_BITS-1:0]            channel,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [15:0]                   voicing,
	input  logic [15:0]                   intensity,
	output logic                          clr_busy,
	output logic [CH_BITS-1:0]            channel_out,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);
	logic [14:0] rate_q;
	logic [2:0]  narrow_q;
	logic [4:0]  wide_q;

	logic [CH_BITS-1:0]            ch_q;
	logic [CHI_BITS-1:0]           chi_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic [15:0]                   tgt_q, inten_q, s_q;
	logic [15:0]                   sv_q [CHANNELS];
	logic [POS_BITS-1:0]           wp_q [CHANNELS];
	logic [22:0]                   offa_q;
	logic [24:0]                   offb_q;
	logic [POS_BITS-1:0]           ta_q, tb_q;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [MIX_BITS-1:0]    mix_q;
	logic [ADDR_BITS:0]            clr_q;

	// clearing sweep of the ring after reset
	assign clr_busy = !clr_q[ADDR_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (clr_busy) clr_q <= clr_q + 1'b1;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= 15'd4096;
			narrow_q <= 3'd1;
			wide_q   <= 5'd7;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RATE:   rate_q <= cfg_data;
				REG_NARROW: narrow_q <= cfg_data[2:0];
				REG_WIDE:   wide_q <= cfg_data[4:0];
				default:    ;
			endcase
		end
	end

	// slide update arithmetic
	logic signed [16:0] diff;
	logic signed [30:0] dprod;
	logic signed [16:0] dstep;
	logic signed [17:0] snew;
	assign diff  = $signed({1'b0, tgt_q}) - $signed({1'b0, sv_q[chi_q]});
	assign dprod = diff * $signed({1'b0, SLIDE_GAIN});
	assign dstep = 17'((dprod + 31'sd8388608) >>> 24);
	assign snew  = $signed({2'b0, sv_q[chi_q]}) + 18'(dstep);

	// offsets
	logic [38:0] sq77;
	logic [40:0] ob;
	logic [37:0] tam;
	logic [39:0] tbm;
	assign sq77 = 39'(s_q) * 39'(s_q) * 39'(SQ_GAIN);
	assign ob   = 41'(offa_q) * 41'(OFFB_GAIN);
	assign tam  = 38'(offa_q) * 38'(rate_q);
	assign tbm  = 40'(offb_q) * 40'(rate_q);

	// ring addressing
	logic [POS_BITS-1:0] wp, pos;
	logic [ADDR_BITS-1:0] raddr, waddr;
	logic [SAMPLE_BITS-1:0] wdata, rdata;
	logic we;
	assign wp = wp_q[chi_q];
	always_comb begin
		case (cmd.tap_idx)
			3'd0: pos = wp + ta_q;
			3'd1: pos = wp + ta_q + POS_BITS'(narrow_q);
			3'd2: pos = wp + ta_q + POS_BITS'({narrow_q, 1'b0});
			3'd3: pos = wp + tb_q;
			3'd4: pos = wp + tb_q + POS_BITS'(wide_q);
			3'd5: pos = wp + tb_q + POS_BITS'({wide_q, 1'b0});
			default: pos = wp;
		endcase
	end
	assign raddr = ADDR_BITS'({chi_q, pos});
	assign we    = clr_busy || cmd.load;
	assign waddr = clr_busy ? clr_q[ADDR_BITS-1:0] :
		ADDR_BITS'({channel[CHI_BITS-1:0], wp_q[channel[CHI_BITS-1:0]]});
	assign wdata = clr_busy ? '0 : sample_in;

	dcvf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MEM_DEPTH)) u_ring (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// tap gain selection
	logic [15:0] g;
	logic        gneg;
	always_comb begin
		case (cmd.acc_idx)
			3'd0, 3'd2: g = GAIN_A_OUT;
			3'd1:       g = GAIN_A_MID;
			3'd3, 3'd5: g = GAIN_B_OUT;
			3'd4:       g = GAIN_B_MID;
			default:    g = '0;
		endcase
		gneg = cmd.acc_idx > 3'd2;
	end
	logic signed [SAMPLE_BITS+16:0] tprod;
	assign tprod = $signed(rdata) * $signed({1'b0, g});

	// mix
	logic signed [MIX_BITS-1:0] mr;
	logic signed [SAMPLE_BITS-1:0] smax, smin;
	assign smax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	assign smin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	assign mr = (mix_q + (MIX_BITS'(1) <<< 33)) >>> 34;

	// sequencing of datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sv_q[i] <= 16'd32768;
				wp_q[i] <= POS_BITS'(RING_DEPTH - 1);
			end
		end else begin
			if (cmd.slide) begin
				sv_q[chi_q] <= (snew < 0) ? 16'd0 : (snew > 18'sd65535) ? 16'hFFFF : snew[15:0];
			end
			if (cmd.mix) wp_q[chi_q] <= wp - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q    <= channel;
			chi_q   <= channel[CHI_BITS-1:0];
			x_q     <= sample_in;
			tgt_q   <= clamp_level(voicing);
			inten_q <= clamp_level(intensity);
		end
		if (cmd.slide)
			s_q <= (snew < 0) ? 16'd0 : (snew > 18'sd65535) ? 16'hFFFF : snew[15:0];
		if (cmd.offa) offa_q <= 23'(sq77 >> 16) + 23'(OFFA_BASE);
		if (cmd.offb) offb_q <= 25'(ob >> 16) + 25'(OFFB_BASE);
		if (cmd.taps) begin
			ta_q <= POS_BITS'(tam >> 28);
			tb_q <= POS_BITS'(tbm >> 28);
			acc_q <= ACC_BITS'(x_q) <<< 16;
		end
		if (cmd.acc_en)
			acc_q <= gneg ? acc_q - ACC_BITS'(tprod) : acc_q + ACC_BITS'(tprod);
		if (cmd.mix)
			mix_q <= MIX_BITS'(acc_q) * $signed({1'b0, inten_q})
				+ ((MIX_BITS'(x_q) * $signed({1'b0, 17'(17'h10000 - 17'(inten_q))})) <<< 18);
		if (cmd.out_load) begin
			channel_out <= ch_q;
			sample_out  <= (mr > MIX_BITS'(smax)) ? smax :
				(mr < MIX_BITS'(smin)) ? smin : mr[SAMPLE_BITS-1:0];
		end
	end

	a_clear_first: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !cmd.load)
		else $error("request taken during ring clear");
	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mix |=> wp_q[$past(chi_q)] == $past(wp) - 1'b1)
		else $error("write position not stepped");
	a_slide_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.offa |-> s_q == sv_q[chi_q])
		else $error("slide mismatch");
endmodule

// File: dv/dual_comb_voicing_filter_checker.sv
// result checker for the dual comb voicing filter: predicts every request and compares
module dual_comb_voicing_filter_checker
	import dcvf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	dcvf_in_if          in_ch,
	dcvf_out_if         out_ch,
	output int          errors,
	output int          outstanding
);

	typedef struct {
		logic [CH_BITS-1:0]            chan;
		logic signed [SAMPLE_BITS-1:0] value;
	} filtered_t;

	filtered_t samples_due[$];

	// model state
	int          ring_mem [CHANNELS][RING_DEPTH];
	longint      slide_val [CHANNELS];
	int          wr_pos [CHANNELS];
	logic [14:0] rate_reg;
	logic [2:0]  narrow_reg;
	logic [4:0]  wide_reg;

	initial begin
		errors = 0;
		outstanding = 0;
		for (int c = 0; c < CHANNELS; c++) begin
			for (int p = 0; p < RING_DEPTH; p++)
				ring_mem[c][p] = 0;
			slide_val[c] = 32768;
			wr_pos[c] = RING_DEPTH - 1;
		end
		rate_reg = 15'd4096;
		narrow_reg = 3'd1;
		wide_reg = 5'd7;
	end

	function automatic longint level_limit(input logic [15:0] v);
		if (v < 16'd655) return 655;
		if (v > 16'd64880) return 64880;
		return longint'(v);
	endfunction

	function automatic longint ring_tap(input int c, input longint pos);
		return longint'(ring_mem[c][pos % RING_DEPTH]);
	endfunction

	// one filter step: slide, offsets, ring write, two clusters, mix and saturate
	function automatic logic [SAMPLE_BITS-1:0] filter_step(input int c,
			input logic signed [SAMPLE_BITS-1:0] smp, input logic [15:0] voi,
			input logic [15:0] inten_raw);
		longint x, tgt, inten, s, offa, offb, ta, tb, wp, pa, pb, acc, mix;
		longint smax, smin;
		x = longint'(smp);
		tgt = level_limit(voi);
		inten = level_limit(inten_raw);
		smax = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		smin = -smax - 1;
		s = slide_val[c];
		s = s + (((tgt - s) * 5033 + (longint'(1) <<< 23)) >>> 24);
		if (s < 0) s = 0;
		if (s > 65535) s = 65535;
		slide_val[c] = s;
		offa = ((s * s * 77) >>> 16) + 209715;
		offb = ((offa * 252314) >>> 16) + (longint'(41) <<< 16);
		ta = (offa * longint'(rate_reg)) >>> 28;
		tb = (offb * longint'(rate_reg)) >>> 28;
		wp = wr_pos[c] % RING_DEPTH;
		ring_mem[c][wp] = int'(x);
		pa = wp + ta;
		pb = wp + tb;
		acc = x * 65536;
		acc += 7021 * ring_tap(c, pa);
		acc += 17957 * ring_tap(c, pa + narrow_reg);
		acc += 7021 * ring_tap(c, pa + 2 * narrow_reg);
		acc -= 37842 * ring_tap(c, pb);
		acc -= 41222 * ring_tap(c, pb + wide_reg);
		acc -= 37842 * ring_tap(c, pb + 2 * wide_reg);
		wr_pos[c] = (wp == 0) ? RING_DEPTH - 1 : int'(wp - 1);
		mix = acc * inten + x * (65536 - inten) * 262144;
		mix = (mix + (longint'(1) <<< 33)) >>> 34;
		if (mix > smax) mix = smax;
		if (mix < smin) mix = smin;
		return mix[SAMPLE_BITS-1:0];
	endfunction

	always @(posedge clk) begin
		filtered_t exp_res;
		if (arst_n) begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_RATE:   rate_reg = cfg_data;
					REG_NARROW: narrow_reg = cfg_data[2:0];
					REG_WIDE:   wide_reg = cfg_data[4:0];
					default: ;
				endcase
			end
			// compare a finished result with the oldest prediction
			if (out_ch.valid && out_ch.ready) begin
				if (samples_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result ch %0d sample %0d",
							out_ch.channel_out, out_ch.sample_out);
				end else begin
					exp_res = samples_due.pop_front();
					if (exp_res.chan !== out_ch.channel_out
							|| exp_res.value !== out_ch.sample_out) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected ch %0d sample %0d, got ch %0d sample %0d",
								exp_res.chan, exp_res.value,
								out_ch.channel_out, out_ch.sample_out);
					end
				end
			end
			// predict each accepted request
			if (in_ch.valid && in_ch.ready) begin
				exp_res.chan = in_ch.channel;
				exp_res.value = filter_step(int'(in_ch.channel) % CHANNELS,
					in_ch.sample_in, in_ch.voicing, in_ch.intensity);
				samples_due.push_back(exp_res);
			end
			outstanding = samples_due.size();
		end
	end

endmodule

// File: dv/dual_comb_voicing_filter_core_test.sv
// testbench top for the dual comb voicing filter: stimulus, handshake pressure and verdict
module dual_comb_voicing_filter_core_test;
	import dcvf_pkg::*;

	localparam int IDLE_LIMIT = 150000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [14:0] cfg_data;
	int          errors;
	int          outstanding;
	int          results_seen;
	int          idle_cycles;
	bit          no_gaps;

	dcvf_in_if  in_ch ();
	dcvf_out_if out_ch ();

	dual_comb_voicing_filter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	dual_comb_voicing_filter_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// watchdog on cycles with no request or result moving
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off while the sender keeps going
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		results_seen = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (results_seen == 120)
				stall = 400;
			else if (no_gaps)
				stall = 0;
			else
				stall = $urandom_range(0, 18);
			if (stall > 0) begin
				out_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			results_seen++;
		end
	end

	task automatic send_request(input logic [3:0] ch, input logic [23:0] smp,
			input logic [15:0] voi, input logic [15:0] inten);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.channel = ch;
		in_ch.sample_in = smp;
		in_ch.voicing = voi;
		in_ch.intensity = inten;
		in_ch.valid = 1'b1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// idle the request side, wait for every result, then let the pipeline settle
	task automatic drain;
		in_ch.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [15:0] pick_level;
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'd655;
			2: return 16'd64880;
			default: return 16'($urandom_range(655, 64880));
		endcase
	endfunction

	function automatic logic [23:0] pick_sample;
		case ($urandom_range(0, 7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'($urandom_range(0, 255)) - 24'd128;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic random_burst(input int count);
		logic [3:0] ch;
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			// a few channels most of the time so the rings fill with real data
			ch = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
				: 4'($urandom_range(0, 2));
			send_request(ch, pick_sample(), pick_level(), pick_level());
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		logic [23:0] edge_smp [3];
		logic [15:0] edge_lvl [4];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_RATE;
		cfg_data = '0;
		no_gaps = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.channel = '0;
		in_ch.sample_in = '0;
		in_ch.voicing = '0;
		in_ch.intensity = '0;
		edge_smp = '{24'h7FFFFF, 24'h800000, 24'h000000};
		edge_lvl = '{16'd0, 16'd655, 16'd64880, 16'd65535};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes on two channels with reset registers
		for (int k = 0; k < 24; k++)
			send_request((k % 2 == 0) ? 4'd0 : 4'd15, edge_smp[k % 3],
				edge_lvl[k % 4], edge_lvl[(k / 4) % 4]);
		drain();

		// sender pause: everything back before going on
		random_burst(150);
		drain();

		write_reg(REG_RATE, 15'd2048);
		write_reg(REG_NARROW, 15'd0);
		write_reg(REG_WIDE, 15'd3);
		write_reg(2'd3, 15'h7FFF);
		random_burst(100);
		drain();

		write_reg(REG_RATE, 15'd16384);
		write_reg(REG_NARROW, 15'd4);
		write_reg(REG_WIDE, 15'd28);
		random_burst(100);
		drain();

		// beyond the ranges that the last random register writes pick from
		write_reg(REG_RATE, 15'h7FFF);
		write_reg(REG_NARROW, 15'h7FFF);
		write_reg(REG_WIDE, 15'h7FFF);
		random_burst(80);
		drain();

		write_reg(REG_RATE, 15'd0);
		write_reg(REG_NARROW, 15'd0);
		write_reg(REG_WIDE, 15'd0);
		random_burst(50);
		drain();

		write_reg(REG_RATE, 15'($urandom_range(2048, 16384)));
		write_reg(REG_NARROW, 15'($urandom_range(0, 4)));
		write_reg(REG_WIDE, 15'($urandom_range(3, 28)));
		random_burst(100);
		drain();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
